// ===== hdl/bba_pkg.sv =====
// ============================================================================
// bba_pkg
// Shared constants, types and helper functions for the buddy block allocator.
// ============================================================================
`default_nettype none

package bba_pkg;

    localparam int MEM_UNITS = 1024;
    localparam int LOG_MEM   = $clog2(MEM_UNITS);
    localparam int ADDR_W    = 10;
    localparam int SIZE_W    = 11;
    localparam int LVL_W     = 4;
    localparam int NODE_W    = LOG_MEM + 1;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int RAM_DEPTH = (2 * MEM_UNITS) / WORD_W;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FAILED    = 2'd1,
        ST_FREED     = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_EV,
        S_SP_RD,
        S_SP_EV,
        S_F_RD,
        S_F_EV,
        S_SE_RD,
        S_SE_EV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [RAM_AW-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

    // first node of a level in heap order
    function automatic logic [NODE_W-1:0] level_base(input logic [LVL_W-1:0] k);
        return NODE_W'(1) << (LOG_MEM - int'(k));
    endfunction

    function automatic logic [NODE_W-1:0] node_of(input logic [ADDR_W-1:0] a,
                                                  input logic [LVL_W-1:0]  k);
        return level_base(k) + NODE_W'(a >> k);
    endfunction

    // ceil(log2(n)); 0 and 1 give 0
    function automatic logic [LVL_W-1:0] size_level(input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] m;
        logic [LVL_W-1:0]  k;
        m = n - SIZE_W'(1);
        k = '0;
        if (n > SIZE_W'(1))
        begin
            for (int i = 0; i < SIZE_W; i++)
            begin
                if (m[i])
                begin
                    k = LVL_W'(i + 1);
                end
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bba_req_if.sv =====
// ============================================================================
// bba_req_if
// Request channel: valid/ready with opcode, size and free address.
// ============================================================================
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, opcode, request_size, free_address, input ready);
    modport sink   (input valid, opcode, request_size, free_address, output ready);
endinterface

`default_nettype wire

// ===== hdl/bba_rsp_if.sv =====
// ============================================================================
// bba_rsp_if
// Result channel: valid/ready with status, block address and block size.
// ============================================================================
`default_nettype none

interface bba_rsp_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [SIZE_W-1:0] block_size;

    modport source (output valid, status, block_address, block_size, input ready);
    modport sink   (input valid, status, block_address, block_size, output ready);
endinterface

`default_nettype wire

// ===== hdl/bba_ram.sv =====
// ============================================================================
// bba_ram
// Generic single-port RAM with registered read.
// ============================================================================
`default_nettype none

module bba_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic                 re,
    input  wire logic [$clog2(D)-1:0] addr,
    input  wire logic [W-1:0]         wdata,
    output logic      [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bba_ctrl.sv =====
// ============================================================================
// bba_ctrl
// Sequencer: scans, splits and merges free marks by read-modify-write.
// ============================================================================
`default_nettype none

module bba_ctrl import bba_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bba_req_if.sink     req,
    bba_rsp_if.source   rsp,
    output mem_req_t    mem,
    input  wire logic [WORD_W-1:0] rdata
);

    state_t            state_reg, state_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [LVL_W-1:0]  kreq_reg, kreq_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [RAM_AW-1:0] word_reg, word_next;
    logic [NODE_W-1:0] node_reg, node_next;
    status_t           res_status_reg, res_status_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [SIZE_W-1:0] out_size_reg, out_size_next;

    // level scan of the word just read
    logic [NODE_W-1:0] lo_node, hi_node, cand;
    logic              hit;
    logic [BIT_W-1:0]  hit_idx;
    logic [NODE_W-1:0] hit_node;
    logic [BIT_W-1:0]  node_bit;

    always_comb
    begin
        lo_node = level_base(lvl_reg);
        hi_node = (lo_node << 1) - NODE_W'(1);
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            cand = {word_reg, BIT_W'(i)};
            if (rdata[i] && cand >= lo_node && cand <= hi_node)
            begin
                hit     = 1'b1;
                hit_idx = BIT_W'(i);
            end
        end
        hit_node = {word_reg, hit_idx};
        node_bit = node_reg[BIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            word_reg      <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kreq_reg       <= kreq_next;
        addr_reg       <= addr_next;
        node_reg       <= node_next;
        res_status_reg <= res_status_next;
        res_size_reg   <= res_size_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_size_reg   <= out_size_next;
    end

    always_comb
    begin
        logic [LVL_W-1:0]  k;
        logic [ADDR_W-1:0] a;
        logic              over;
        logic [LVL_W-1:0]  kn;
        state_next      = state_reg;
        lvl_next        = lvl_reg;
        kreq_next       = kreq_reg;
        addr_next       = addr_reg;
        word_next       = word_reg;
        node_next       = node_reg;
        res_status_next = res_status_reg;
        res_size_next   = res_size_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_size_next   = out_size_reg;
        mem             = '0;
        req.ready       = 1'b0;
        k    = size_level(req.request_size);
        over = req.request_size > SIZE_W'(MEM_UNITS);
        a    = '0;
        kn   = '0;

        if (rsp.ready && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem.we    = 1'b1;
                mem.addr  = word_reg;
                mem.wdata = (word_reg == '0) ? (WORD_W'(1) << 1) : '0;
                word_next = word_reg + RAM_AW'(1);
                if (word_reg == RAM_AW'(RAM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    kreq_next = k;
                    if (req.opcode == OP_ALLOC)
                    begin
                        if (over)
                        begin
                            res_status_next = ST_FAILED;
                            res_size_next   = '0;
                            addr_next       = '0;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            lvl_next   = k;
                            word_next  = RAM_AW'(level_base(k) >> BIT_W);
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        if (over)
                        begin
                            k = LVL_W'(LOG_MEM);
                        end
                        a = (req.free_address & ADDR_W'(MEM_UNITS - 1))
                            & ~((ADDR_W'(1) << k) - ADDR_W'(1));
                        lvl_next  = k;
                        addr_next = a;
                        if (k == LVL_W'(LOG_MEM))
                        begin
                            node_next  = node_of(a, k);
                            state_next = S_SE_RD;
                        end
                        else
                        begin
                            node_next  = node_of(a ^ (ADDR_W'(1) << k), k);
                            state_next = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD:
            begin
                mem.re     = 1'b1;
                mem.addr   = word_reg;
                state_next = S_A_EV;
            end
            S_A_EV:
            begin
                if (hit)
                begin
                    mem.we    = 1'b1;
                    mem.addr  = word_reg;
                    mem.wdata = rdata & ~(WORD_W'(1) << hit_idx);
                    a         = ADDR_W'((hit_node - lo_node) << lvl_reg);
                    addr_next = a;
                    res_status_next = ST_ALLOCATED;
                    res_size_next   = SIZE_W'(1) << kreq_reg;
                    if (lvl_reg > kreq_reg)
                    begin
                        kn         = lvl_reg - LVL_W'(1);
                        lvl_next   = kn;
                        node_next  = node_of(a + (ADDR_W'(1) << kn), kn);
                        state_next = S_SP_RD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (word_reg == hi_node[NODE_W-1:BIT_W])
                begin
                    if (lvl_reg == LVL_W'(LOG_MEM))
                    begin
                        res_status_next = ST_FAILED;
                        res_size_next   = '0;
                        addr_next       = '0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        kn         = lvl_reg + LVL_W'(1);
                        lvl_next   = kn;
                        word_next  = RAM_AW'(level_base(kn) >> BIT_W);
                        state_next = S_A_RD;
                    end
                end
                else
                begin
                    word_next  = word_reg + RAM_AW'(1);
                    state_next = S_A_RD;
                end
            end
            S_SP_RD:
            begin
                mem.re     = 1'b1;
                mem.addr   = node_reg[NODE_W-1:BIT_W];
                state_next = S_SP_EV;
            end
            S_SP_EV:
            begin
                mem.we    = 1'b1;
                mem.addr  = node_reg[NODE_W-1:BIT_W];
                mem.wdata = rdata | (WORD_W'(1) << node_bit);
                if (lvl_reg > kreq_reg)
                begin
                    kn         = lvl_reg - LVL_W'(1);
                    lvl_next   = kn;
                    node_next  = node_of(addr_reg + (ADDR_W'(1) << kn), kn);
                    state_next = S_SP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_F_RD:
            begin
                mem.re     = 1'b1;
                mem.addr   = node_reg[NODE_W-1:BIT_W];
                state_next = S_F_EV;
            end
            S_F_EV:
            begin
                if (rdata[node_bit])
                begin
                    mem.we    = 1'b1;
                    mem.addr  = node_reg[NODE_W-1:BIT_W];
                    mem.wdata = rdata & ~(WORD_W'(1) << node_bit);
                    a         = addr_reg & ~(ADDR_W'(1) << lvl_reg);
                    kn        = lvl_reg + LVL_W'(1);
                    addr_next = a;
                    lvl_next  = kn;
                    if (kn == LVL_W'(LOG_MEM))
                    begin
                        node_next  = node_of(a, kn);
                        state_next = S_SE_RD;
                    end
                    else
                    begin
                        node_next  = node_of(a ^ (ADDR_W'(1) << kn), kn);
                        state_next = S_F_RD;
                    end
                end
                else
                begin
                    node_next  = node_of(addr_reg, lvl_reg);
                    state_next = S_SE_RD;
                end
            end
            S_SE_RD:
            begin
                mem.re     = 1'b1;
                mem.addr   = node_reg[NODE_W-1:BIT_W];
                state_next = S_SE_EV;
            end
            S_SE_EV:
            begin
                mem.we          = 1'b1;
                mem.addr        = node_reg[NODE_W-1:BIT_W];
                mem.wdata       = rdata | (WORD_W'(1) << node_bit);
                res_status_next = ST_FREED;
                res_size_next   = SIZE_W'(1) << lvl_reg;
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = addr_reg;
                    out_size_next   = res_size_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.block_address = out_addr_reg;
    assign rsp.block_size    = out_size_reg;

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem.we && mem.re))
        else $error("RAM read and write in one cycle");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE && state_reg != S_CLEAR |-> lvl_reg <= LVL_W'(LOG_MEM))
        else $error("level out of range");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result loaded outside finish state");

    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_A_EV |-> $past(state_reg) == S_A_RD)
        else $error("scan evaluated without a read");

endmodule

`default_nettype wire

// ===== hdl/buddy_block_allocator_top.sv =====
// ============================================================================
// buddy_block_allocator_top
// Buddy allocator over 1024 units with free marks kept in a block RAM.
// ============================================================================
// Usage:
//   req : request channel (valid/ready). opcode 0 allocates request_size units
//         (rounded up to a power of two), opcode 1 frees the block at
//         free_address and merges it with free buddies.
//   rsp : one result per request: status, block_address, block_size.
// Free marks live in a 64 x 32 single-port RAM, one bit per heap node.
// Each mark update is a read-modify-write on that port.
// Free reads each buddy's mark and, while the buddy is free, clears it and
// merges upward, then sets the mark of the merged block.
// Allocate scans one RAM word at a time from the requested level upward
// (up to 68 words), then sets the buddy mark of each split level; a size
// beyond the memory fails without a RAM access.
// One request is in flight at a time; ready is high only while idle.
// After reset the RAM is swept word by word (whole memory marked free),
// during which no request is taken.
// The result sits in an output register; a new request is accepted while it
// waits, and the next result waits in the sequencer until the slot drains.
// ============================================================================
`default_nettype none

module buddy_block_allocator_top import bba_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);

    mem_req_t          mem;
    logic [WORD_W-1:0] rdata;

    bba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .mem   (mem),
        .rdata (rdata)
    );

    bba_ram #(
        .W (WORD_W),
        .D (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .re    (mem.re),
        .addr  (mem.addr),
        .wdata (mem.wdata),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

// ===== verif/tb_buddy_block_allocator_top.sv =====
// ============================================================================
// tb_buddy_block_allocator_top
// Self-checking regression of the buddy allocator: directed and random
// allocate/free requests, results checked against an internal free-mark model.
// ============================================================================
`timescale 1ns / 1ps

module tb_buddy_block_allocator_top;
    import bba_pkg::*;

    typedef struct packed {
        opcode_t           op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } alloc_req_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bba_req_if req ();
    bba_rsp_if rsp ();

    buddy_block_allocator_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #4 clk = ~clk;

    alloc_req_t pending_reqs[$];
    alloc_rsp_t expected_rsps[$];
    logic       free_marks[2*MEM_UNITS];
    int         fail_count = 0;
    bit         quiet = 1'b0;
    bit         hold_send = 1'b0;
    int         send_gap = 0;
    int         recv_gap = 0;

    function automatic int heap_node(int a, int s);
        return MEM_UNITS / s + a / s;
    endfunction

    function automatic int round_up(int n);
        int p;
        p = 1;
        while (p < n && p <= MEM_UNITS)
        begin
            p = p << 1;
        end
        return p;
    endfunction

    function automatic alloc_rsp_t allocate_or_free(alloc_req_t r);
        alloc_rsp_t o;
        int         want;
        int         s;
        int         a;
        int         cur;
        int         b;
        bit         found;
        want = round_up(int'(r.size));
        o.status = ST_FAILED;
        o.addr = '0;
        o.size = '0;
        found = 1'b0;
        if (r.op == OP_ALLOC)
        begin
            if (want <= MEM_UNITS)
            begin
                for (s = want; s <= MEM_UNITS && !found; s = s << 1)
                begin
                    for (a = 0; a < MEM_UNITS && !found; a += s)
                    begin
                        if (free_marks[heap_node(a, s)])
                        begin
                            free_marks[heap_node(a, s)] = 1'b0;
                            cur = s;
                            while (cur > want)
                            begin
                                cur = cur >> 1;
                                free_marks[heap_node(a + cur, cur)] = 1'b1;
                            end
                            o.status = ST_ALLOCATED;
                            o.addr = ADDR_W'(a);
                            o.size = SIZE_W'(want);
                            found = 1'b1;
                        end
                    end
                end
            end
        end
        else
        begin
            s = (want > MEM_UNITS) ? MEM_UNITS : want;
            a = int'(r.addr) & (MEM_UNITS - 1);
            a = a & ~(s - 1);
            while (s < MEM_UNITS)
            begin
                b = a ^ s;
                if (!free_marks[heap_node(b, s)])
                begin
                    break;
                end
                free_marks[heap_node(b, s)] = 1'b0;
                if (b < a)
                begin
                    a = b;
                end
                s = s << 1;
            end
            free_marks[heap_node(a, s)] = 1'b1;
            o.status = ST_FREED;
            o.addr = ADDR_W'(a);
            o.size = SIZE_W'(s);
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic push_req(opcode_t op, int size, int addr);
        alloc_req_t r;
        r.op = op;
        r.size = SIZE_W'(size);
        r.addr = ADDR_W'(addr);
        pending_reqs.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.opcode <= 1'b0;
            req.request_size <= '0;
            req.free_address <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_rsps.push_back(allocate_or_free(alloc_req_t'(
                    {req.opcode, req.request_size, req.free_address})));
            end
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req.valid <= 1'b0;
                end
                else if (!hold_send && pending_reqs.size() > 0 &&
                         (quiet || $urandom_range(0, 9) != 0))
                begin
                    alloc_req_t r;
                    r = pending_reqs.pop_front();
                    req.valid <= 1'b1;
                    req.opcode <= r.op;
                    req.request_size <= r.size;
                    req.free_address <= r.addr;
                end
                else
                begin
                    req.valid <= 1'b0;
                    if (!quiet && $urandom_range(0, 9) == 0)
                    begin
                        send_gap <= $urandom_range(0, 7);
                    end
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    report_mismatch("unexpected result, status", int'(rsp.status), -1);
                end
                else
                begin
                    alloc_rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.status !== e.status)
                        report_mismatch("status", int'(rsp.status), int'(e.status));
                    if (rsp.block_address !== e.addr)
                        report_mismatch("block_address", int'(rsp.block_address),
                                        int'(e.addr));
                    if (rsp.block_size !== e.size)
                        report_mismatch("block_size", int'(rsp.block_size), int'(e.size));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                rsp.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                recv_gap <= $urandom_range(0, 7);
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int k;
        int sz;
        for (k = 0; k < 2 * MEM_UNITS; k++)
        begin
            free_marks[k] = 1'b0;
        end
        free_marks[heap_node(0, MEM_UNITS)] = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        push_req(OP_ALLOC, 0, 1023);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_ALLOC, 3, 0);
        push_req(OP_ALLOC, 1025, 0);
        push_req(OP_ALLOC, 2047, 0);
        push_req(OP_ALLOC, 1024, 0);
        push_req(OP_FREE, 1, 0);
        push_req(OP_FREE, 1, 0);
        push_req(OP_FREE, 1, 1);
        push_req(OP_FREE, 4, 6);
        push_req(OP_ALLOC, 1024, 0);
        push_req(OP_ALLOC, 512, 0);
        push_req(OP_ALLOC, 512, 0);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_FREE, 2047, 1023);
        push_req(OP_ALLOC, 1024, 0);
        push_req(OP_FREE, 1024, 1023);
        push_req(OP_FREE, 0, 1023);
        push_req(OP_ALLOC, 16, 0);
        push_req(OP_FREE, 1536, 512);
        wait_drained();

        // hold a queued request back, then release it
        hold_send = 1'b1;
        push_req(OP_ALLOC, 7, 0);
        repeat (20) @(posedge clk);
        hold_send = 1'b0;
        push_req(OP_FREE, 2047, 0);
        wait_drained();

        // random allocs/frees of random size and address; periodic full free
        for (k = 0; k < 780; k++)
        begin
            if (k == 700)
            begin
                wait_drained();
                quiet = 1'b1;
            end
            if (k % 120 == 119)
            begin
                wait_drained();
                push_req(OP_FREE, 2047, $urandom_range(0, 1023));
                continue;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    sz = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                    : $urandom_range(0, 64);
                    push_req(OP_ALLOC, sz, $urandom_range(0, 1023));
                    wait_drained();
                end
                default:
                begin
                    push_req(OP_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
                end
            endcase
        end
        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("buddy_block_allocator_top regression: pass");
        end
        else
        begin
            $display("buddy_block_allocator_top regression: fail");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("buddy_block_allocator_top regression: fail");
        $finish;
    end
endmodule
